FILE: hw/rtl/sql_parameter_marker_finder_assert.svh
// Assertion macros for the marker finder.
// Each takes a label, clock, active-low reset, antecedent and consequent.
`ifndef SQL_PARAMETER_MARKER_FINDER_ASSERT_SVH
`define SQL_PARAMETER_MARKER_FINDER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define SPMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("marker finder check failed");

// Next-cycle implication.
`define SPMF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("marker finder check failed");

`else

`define SPMF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPMF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/sqlpmf_pkg.sv
package sqlpmf_pkg;

	localparam int MAX_STATEMENT_BYTES = 65536;
	localparam logic [15:0] POS_CEIL = (MAX_STATEMENT_BYTES - 1 > 65535) ? 16'hFFFF
		: 16'(MAX_STATEMENT_BYTES - 1);
	localparam logic [15:0] COUNT_CEIL = 16'hFFFF;

	// scan modes
	localparam logic [2:0] M_NORMAL     = 3'd0;
	localparam logic [2:0] M_PEND_DASH  = 3'd1;
	localparam logic [2:0] M_PEND_SLASH = 3'd2;
	localparam logic [2:0] M_LINE       = 3'd3;
	localparam logic [2:0] M_BLOCK      = 3'd4;
	localparam logic [2:0] M_BLOCK_STAR = 3'd5;
	localparam logic [2:0] M_QUOTE      = 3'd6;
	localparam logic [2:0] M_QUOTE_END  = 3'd7;

	// quote kinds
	localparam logic [1:0] Q_NONE   = 2'd0;
	localparam logic [1:0] Q_SINGLE = 2'd1;
	localparam logic [1:0] Q_DOUBLE = 2'd2;
	localparam logic [1:0] Q_BTICK  = 2'd3;

	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BTICK  = 8'h60;

	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] quote;
		logic       marker;
	} scan_t;

	function automatic logic [7:0] quote_char(input logic [1:0] kind);
		logic [7:0] ch;
		unique case (kind)
			Q_SINGLE: ch = CH_SQUOTE;
			Q_DOUBLE: ch = CH_DQUOTE;
			Q_BTICK:  ch = CH_BTICK;
			default:  ch = 8'h00;
		endcase
		return ch;
	endfunction

	// one byte as plain text; quote kind kept unless a quote opens
	function automatic scan_t scan_normal(input logic [7:0] c, input logic [1:0] q_in);
		scan_t r;
		r.mode   = M_NORMAL;
		r.quote  = q_in;
		r.marker = 1'b0;
		unique case (c)
			CH_DASH:   r.mode = M_PEND_DASH;
			CH_SLASH:  r.mode = M_PEND_SLASH;
			CH_SQUOTE: begin
				r.mode  = M_QUOTE;
				r.quote = Q_SINGLE;
			end
			CH_DQUOTE: begin
				r.mode  = M_QUOTE;
				r.quote = Q_DOUBLE;
			end
			CH_BTICK:  begin
				r.mode  = M_QUOTE;
				r.quote = Q_BTICK;
			end
			CH_QMARK:  r.marker = 1'b1;
			default:   r.marker = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/sql_parameter_marker_finder.sv
// SQL parameter marker finder. Takes one statement byte per transaction on the
// s_axis side (tlast on the final byte) and gives a result transaction on the
// m_axis side for every '?' outside comments and quoted text, and one on the
// final byte carrying the marker count. Comments are "--" to CR/LF and
// slash-star blocks; strings use single, double or backtick quotes, a doubled
// quote staying inside. Bytes are accepted one per cycle unless the m_axis side
// stalls: each byte lands in an input register, the scan state and the result
// are updated from that register when the byte passes on, and the result sits
// in an output register. While the m_axis side stalls with a result held, a
// byte that owes a result waits in the input register and s_axis_tready drops;
// bytes that owe no result pass on regardless. Position and count saturate at
// 65535 and raise the overflow bit; all state clears after the final byte.
module sql_parameter_marker_finder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [15:0] marker_position, [31:16] marker_count,
	                                    // [32] overflow, [39:33] zero
	output logic [0:0]  m_axis_tuser,   // [0] is_marker
	output logic        m_axis_tlast    // is_last
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// scan state
	logic [2:0]  mode_q;
	logic [1:0]  quote_q;
	logic [15:0] index_q;
	logic [15:0] count_q;
	logic        sat_q;

	// output register
	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic        out_marker_q;
	logic        out_last_q;

	logic [2:0]  mode_nxt;
	logic [1:0]  quote_nxt;
	logic [15:0] index_nxt;
	logic [15:0] count_nxt;
	logic        sat_nxt;
	logic [15:0] pos;
	logic        marker;
	logic [7:0]  qch;
	logic        has_result;
	logic        out_free;
	logic        adv_s1;
	sqlpmf_pkg::scan_t sn;

	assign qch = sqlpmf_pkg::quote_char(quote_q);
	assign sn  = sqlpmf_pkg::scan_normal(char_s1, quote_q);

	// scan step for the byte in the input register
	always_comb begin
		mode_nxt  = mode_q;
		quote_nxt = quote_q;
		marker    = 1'b0;
		sat_nxt   = sat_q;
		pos       = index_q;
		if (index_q >= sqlpmf_pkg::POS_CEIL) begin
			pos       = sqlpmf_pkg::POS_CEIL;
			index_nxt = sqlpmf_pkg::POS_CEIL;
			sat_nxt   = 1'b1;
		end else begin
			index_nxt = index_q + 16'd1;
		end
		unique case (mode_q)
			sqlpmf_pkg::M_PEND_DASH: begin
				if (char_s1 == sqlpmf_pkg::CH_DASH) begin
					mode_nxt = sqlpmf_pkg::M_LINE;
				end else begin
					mode_nxt  = sn.mode;
					quote_nxt = sn.quote;
					marker    = sn.marker;
				end
			end
			sqlpmf_pkg::M_PEND_SLASH: begin
				if (char_s1 == sqlpmf_pkg::CH_STAR) begin
					mode_nxt = sqlpmf_pkg::M_BLOCK;
				end else begin
					mode_nxt  = sn.mode;
					quote_nxt = sn.quote;
					marker    = sn.marker;
				end
			end
			sqlpmf_pkg::M_LINE: begin
				if (char_s1 == sqlpmf_pkg::CH_LF || char_s1 == sqlpmf_pkg::CH_CR) begin
					mode_nxt = sqlpmf_pkg::M_NORMAL;
				end
			end
			sqlpmf_pkg::M_BLOCK: begin
				if (char_s1 == sqlpmf_pkg::CH_STAR) begin
					mode_nxt = sqlpmf_pkg::M_BLOCK_STAR;
				end
			end
			sqlpmf_pkg::M_BLOCK_STAR: begin
				if (char_s1 == sqlpmf_pkg::CH_SLASH) begin
					mode_nxt = sqlpmf_pkg::M_NORMAL;
				end else if (char_s1 != sqlpmf_pkg::CH_STAR) begin
					mode_nxt = sqlpmf_pkg::M_BLOCK;
				end
			end
			sqlpmf_pkg::M_QUOTE: begin
				if (char_s1 == qch) begin
					mode_nxt = sqlpmf_pkg::M_QUOTE_END;
				end
			end
			sqlpmf_pkg::M_QUOTE_END: begin
				// doubled quote stays in the string, anything else closes it
				if (char_s1 == qch) begin
					mode_nxt = sqlpmf_pkg::M_QUOTE;
				end else begin
					mode_nxt  = sn.mode;
					quote_nxt = (sn.mode == sqlpmf_pkg::M_QUOTE) ? sn.quote
						: sqlpmf_pkg::Q_NONE;
					marker    = sn.marker;
				end
			end
			default: begin
				mode_nxt  = sn.mode;
				quote_nxt = sn.quote;
				marker    = sn.marker;
			end
		endcase
		count_nxt = count_q;
		if (marker) begin
			if (count_q >= sqlpmf_pkg::COUNT_CEIL) begin
				count_nxt = sqlpmf_pkg::COUNT_CEIL;
				sat_nxt   = 1'b1;
			end else begin
				count_nxt = count_q + 16'd1;
			end
		end
	end

	assign has_result    = marker | last_s1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && (!has_result || out_free);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// scan state; the final byte returns everything to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sqlpmf_pkg::M_NORMAL;
			quote_q <= sqlpmf_pkg::Q_NONE;
			index_q <= 16'd0;
			count_q <= 16'd0;
			sat_q   <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				mode_q  <= sqlpmf_pkg::M_NORMAL;
				quote_q <= sqlpmf_pkg::Q_NONE;
				index_q <= 16'd0;
				count_q <= 16'd0;
				sat_q   <= 1'b0;
			end else begin
				mode_q  <= mode_nxt;
				quote_q <= quote_nxt;
				index_q <= index_nxt;
				count_q <= count_nxt;
				sat_q   <= sat_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && has_result) begin
			out_data_q   <= {7'd0, sat_nxt,
				(last_s1 ? count_nxt : 16'd0),
				(marker ? pos : 16'd0)};
			out_marker_q <= marker;
			out_last_q   <= last_s1;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_marker_q;
	assign m_axis_tlast    = out_last_q;

	`include "sql_parameter_marker_finder_assert.svh"

	// every result is a marker, the end of a statement, or both
	`SPMF_ASSERT_IMP(a_result_kind, clk, arst_n, m_axis_tvalid, m_axis_tuser[0] || m_axis_tlast)

	// the count field is only filled on the final result
	`SPMF_ASSERT_IMP(a_count_on_last, clk, arst_n, m_axis_tvalid && !m_axis_tlast,
		m_axis_tdata[31:16] == 16'd0)

	// a final byte leaves the scanner in plain text at position zero
	`SPMF_ASSERT_NXT(a_clear_after_last, clk, arst_n, adv_s1 && last_s1,
		mode_q == sqlpmf_pkg::M_NORMAL && index_q == 16'd0 && count_q == 16'd0)

	// string state always carries a quote kind
	`SPMF_ASSERT_IMP(a_quote_kind, clk, arst_n,
		mode_q == sqlpmf_pkg::M_QUOTE || mode_q == sqlpmf_pkg::M_QUOTE_END,
		quote_q != sqlpmf_pkg::Q_NONE)

endmodule
